FILE: rtl/core/base45_stream_decoder_assert.svh
// Assertion macros for the base45 stream decoder RTL.
`ifndef BASE45_STREAM_DECODER_ASSERT_SVH
`define BASE45_STREAM_DECODER_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define B45_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define B45_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/bs45_pkg.sv
package bs45_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_CHAR = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;
  localparam status_t ST_BAD_LEN  = 2'd3;

  localparam logic [5:0] DIGIT_INVALID = 6'd45;

  // One queued job: one or two results produced by a single input item.
  typedef struct packed {
    logic    two_bytes;
    logic [7:0] byte_hi;
    logic [7:0] byte_lo;
    status_t status;
    logic    msg_end;
  } job_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a character byte to its Base45 digit, DIGIT_INVALID if not in the alphabet.
  function automatic logic [5:0] digit_of(input logic [7:0] ch);
    logic [5:0] d;
    d = DIGIT_INVALID;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = 6'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = 6'(ch - 8'h41 + 8'd10);
    end else begin
      unique case (ch)
        8'h20:   d = 6'd36;
        8'h24:   d = 6'd37;
        8'h25:   d = 6'd38;
        8'h2A:   d = 6'd39;
        8'h2B:   d = 6'd40;
        8'h2D:   d = 6'd41;
        8'h2E:   d = 6'd42;
        8'h2F:   d = 6'd43;
        8'h3A:   d = 6'd44;
        default: d = DIGIT_INVALID;
      endcase
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/bs45_front.sv
module bs45_front
  import bs45_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  q_stat_t    q_stat,
  output logic       push,
  output job_t       push_job
);

  logic [1:0]  held_r, held_nxt;
  logic [10:0] part_r, part_nxt;
  logic        disc_r, disc_nxt;

  logic        accept;
  logic [5:0]  digit;
  logic [11:0] val2;
  logic [16:0] val3;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign digit     = digit_of(in_tdata);
  assign val2      = 12'(part_r) + 12'(digit) * 12'd45;
  assign val3      = 17'(part_r) + 17'(digit) * 17'd2025;

  always_comb begin
    held_nxt = held_r;
    part_nxt = part_r;
    disc_nxt = disc_r;
    push     = 1'b0;
    push_job = '0;
    if (accept) begin
      if (disc_r) begin
        // drop until the end flag
        if (in_tlast) begin
          disc_nxt = 1'b0;
          held_nxt = 2'd0;
          part_nxt = '0;
        end
      end else if (digit == DIGIT_INVALID) begin
        held_nxt         = 2'd0;
        part_nxt         = '0;
        disc_nxt         = !in_tlast;
        push             = 1'b1;
        push_job.status  = ST_BAD_CHAR;
        push_job.msg_end = 1'b1;
      end else begin
        unique case (held_r)
          2'd0: begin
            if (in_tlast) begin
              part_nxt         = '0;
              push             = 1'b1;
              push_job.status  = ST_BAD_LEN;
              push_job.msg_end = 1'b1;
            end else begin
              part_nxt = 11'(digit);
              held_nxt = 2'd1;
            end
          end
          2'd1: begin
            if (!in_tlast) begin
              part_nxt = val2[10:0];
              held_nxt = 2'd2;
            end else begin
              held_nxt         = 2'd0;
              part_nxt         = '0;
              push             = 1'b1;
              push_job.msg_end = 1'b1;
              if (val2 > 12'd255) begin
                push_job.status = ST_OVERFLOW;
              end else begin
                push_job.status  = ST_OK;
                push_job.byte_lo = val2[7:0];
              end
            end
          end
          default: begin
            held_nxt = 2'd0;
            part_nxt = '0;
            push     = 1'b1;
            if (val3 > 17'hFFFF) begin
              disc_nxt         = !in_tlast;
              push_job.status  = ST_OVERFLOW;
              push_job.msg_end = 1'b1;
            end else begin
              push_job.two_bytes = 1'b1;
              push_job.byte_hi   = val3[15:8];
              push_job.byte_lo   = val3[7:0];
              push_job.status    = ST_OK;
              push_job.msg_end   = in_tlast;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      part_r <= '0;
      disc_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      part_r <= part_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

FILE: rtl/core/bs45_queue.sv
module bs45_queue
  import bs45_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  job_t                         push_job,
  input  logic                         pop,
  output job_t                         head_job,
  output q_stat_t                      q_stat,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  assign head_job     = slots[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign level        = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) cnt_r <= CW'(cnt_r + 1'b1);
      else if (pop && !push) cnt_r <= CW'(cnt_r - 1'b1);
    end
  end

endmodule

FILE: rtl/core/bs45_back.sv
module bs45_back
  import bs45_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head_job,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_byte,
  output status_t    out_status,
  output logic       out_run_end,
  output logic       out_msg_end
);

  logic       out_valid_r;
  logic [7:0] byte_r;
  status_t    status_r;
  logic       run_end_r;
  logic       msg_end_r;
  // second byte of a two-byte job, waiting for the output register
  logic       pend_r;
  logic [7:0] pend_byte_r;
  logic       pend_msg_r;

  logic       load;

  assign load = !out_valid_r || out_tready;
  assign pop  = load && !pend_r && !q_stat.empty;

  assign out_tvalid  = out_valid_r;
  assign out_byte    = byte_r;
  assign out_status  = status_r;
  assign out_run_end = run_end_r;
  assign out_msg_end = msg_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_r <= 1'b1;
        pend_r      <= head_job.two_bytes;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        byte_r    <= pend_byte_r;
        status_r  <= ST_OK;
        run_end_r <= 1'b1;
        msg_end_r <= pend_msg_r;
      end else if (head_job.two_bytes) begin
        byte_r      <= head_job.byte_hi;
        status_r    <= ST_OK;
        run_end_r   <= 1'b0;
        msg_end_r   <= 1'b0;
        pend_byte_r <= head_job.byte_lo;
        pend_msg_r  <= head_job.msg_end;
      end else begin
        byte_r    <= head_job.byte_lo;
        status_r  <= head_job.status;
        run_end_r <= 1'b1;
        msg_end_r <= head_job.msg_end;
      end
    end
  end

endmodule

FILE: rtl/core/base45_stream_decoder.sv
// Base45 (RFC 9285) stream decoder. Feed one character byte per item on the
// in_ channel, with in_tlast on the last character of the string. Groups of
// three characters c,d,e decode to n = c + 45*d + 2025*e, sent as two bytes,
// high byte first; a closing group of two characters gives one byte. Every
// result carries a status: ok, invalid character, value overflow, or bad
// length (one character left over). After an error one error result is sent
// and characters are dropped up to and including the next in_tlast. A new
// character is taken every cycle while the job queue (QUEUE_DEPTH entries)
// has room; digit lookup and the constant multiply-add finish in the cycle
// of acceptance. The output side delivers one result per cycle while
// out_tready is high, so a string of full groups sustains two results per
// three characters with no stall; the back end turns a two-byte group into
// two results, popping no job meanwhile, which bounds throughput only when
// results outpace characters. Results pass the queue and output register.
`include "base45_stream_decoder_assert.svh"

module base45_stream_decoder
  import bs45_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // is_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [7:0] out_tuser,  // [1:0] status, [2] run_end, [7:3] zero
  output logic       out_tlast   // message_end
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          head_job;
  q_stat_t       q_stat;
  logic [CW-1:0] level;

  status_t       res_status;
  logic          res_run_end;

  // Front: classify each character and update the group state.
  bs45_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Queue of pending jobs between front and back.
  bs45_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat),
    .level    (level)
  );

  // Back: split jobs into results and hold them in the output register.
  bs45_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_tdata),
    .out_status  (res_status),
    .out_run_end (res_run_end),
    .out_msg_end (out_tlast)
  );

  assign out_tuser = {5'd0, res_run_end, res_status};

  // Queue never takes a job when full, never gives one when empty.
  `B45_ASSERT_ON(a_no_overflow, push |-> !q_stat.full, "job queue overflow")
  `B45_ASSERT_ON(a_no_underflow, pop |-> !q_stat.empty, "job queue underflow")
  `B45_ASSERT_ON(a_level_range, level <= CW'(QUEUE_DEPTH), "queue level out of range")
  // Output is idle right after reset.
  `B45_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
